### sv/ttb_pkg.sv
// shared types and constants for the triangle tangent basis unit
package ttb_pkg;

    localparam int POS_W  = 32;
    localparam int TEX_W  = 16;
    localparam int EDGE_W = 33;
    localparam int DUV_W  = 17;
    localparam int DET_W  = 35;
    localparam int PROD_W = 50;
    localparam int NUM_W  = 62;
    localparam int QCNT_W = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET,
        ST_NUM,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load_det;
        logic       mul_step;
        logic       div_start;
        logic       div_step;
        logic       store_q;
        logic [2:0] sel;
        logic       sel_bit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic det_zero;
    } stat_t;

endpackage

### sv/triangle_tangent_basis_unit.sv
// top level of the triangle tangent basis unit
//  channel  | dir | payload
//  s_axis   | in  | one triangle corner per transfer
//  m_axis   | out | one basis per completed triangle
// corners one and two are stored as they arrive; after the third the result is
// offered once the determinant products are formed and, per component, the two
// multiplies, the numerator load, the divide (setup and one-bit steps) and the
// store are done; the divide is skipped when the uv determinant is zero. reset clears the
// corner count. input is held off while a triangle is worked or its result waits.
module triangle_tangent_basis_unit #(
    parameter int INDEX_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [((INDEX_BITS+128+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // index_a, index_b, index_c, tangent_x..z, bitangent_x..z
    output logic [((3*INDEX_BITS+192+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic m_axis_tuser,
    output logic m_axis_tlast
);
    localparam int IB = INDEX_BITS;
    localparam int OW = ((3*INDEX_BITS+192+7)/8)*8;

    ttb_pkg::cmd_t  cmd;
    ttb_pkg::stat_t stat;
    logic in_fire, corner_we, corner_sel, tri_load, done_flag;
    logic [IB-1:0] ia, ib, ic;
    logic [6*32-1:0] vec;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    ttb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
        .out_ready(m_axis_tready), .stat(stat), .s_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .corner_we(corner_we), .corner_sel(corner_sel),
        .tri_load(tri_load), .done_flag(done_flag), .cmd(cmd)
    );

    ttb_datapath #(.INDEX_BITS(INDEX_BITS)) u_dp (
        .clk(clk), .corner_we(corner_we), .corner_sel(corner_sel),
        .tri_load(tri_load),
        .vertex_index(s_axis_tdata[IB-1:0]),
        .pos_x(s_axis_tdata[IB+31:IB]),
        .pos_y(s_axis_tdata[IB+63:IB+32]),
        .pos_z(s_axis_tdata[IB+95:IB+64]),
        .tex_u(s_axis_tdata[IB+111:IB+96]),
        .tex_v(s_axis_tdata[IB+127:IB+112]),
        .cmd(cmd), .stat(stat),
        .index_a(ia), .index_b(ib), .index_c(ic), .vec(vec)
    );

    assign m_axis_tdata = OW'({vec, ic, ib, ia});
    assign m_axis_tuser = stat.det_zero;
    assign m_axis_tlast = done_flag;
endmodule

### sv/ttb_datapath.sv
// datapath: corner storage, deltas, shared multiplier, serial divider
module ttb_datapath #(
    parameter int INDEX_BITS = 16
) (
    input  logic                        clk,
    input  logic                        corner_we,
    input  logic                        corner_sel,
    input  logic                        tri_load,
    input  logic [INDEX_BITS-1:0]       vertex_index,
    input  logic signed [31:0]          pos_x,
    input  logic signed [31:0]          pos_y,
    input  logic signed [31:0]          pos_z,
    input  logic signed [15:0]          tex_u,
    input  logic signed [15:0]          tex_v,
    input  ttb_pkg::cmd_t               cmd,
    output ttb_pkg::stat_t              stat,
    output logic [INDEX_BITS-1:0]       index_a,
    output logic [INDEX_BITS-1:0]       index_b,
    output logic [INDEX_BITS-1:0]       index_c,
    output logic [6*32-1:0]             vec
);
    localparam int EDGE_W = ttb_pkg::EDGE_W;
    localparam int DUV_W  = ttb_pkg::DUV_W;

    logic signed [31:0] pa_reg [3];
    logic signed [31:0] pb_reg [3];
    logic signed [15:0] ua_reg, va_reg, ub_reg, vb_reg;
    logic [INDEX_BITS-1:0] ia_reg, ib_reg, ic_reg;
    logic signed [ttb_pkg::EDGE_W-1:0] e1_reg [3];
    logic signed [ttb_pkg::EDGE_W-1:0] e2_reg [3];
    logic signed [ttb_pkg::DUV_W-1:0] d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic signed [ttb_pkg::DET_W-1:0] det_reg;
    logic signed [ttb_pkg::PROD_W-1:0] p1_reg, p2_reg;
    logic signed [ttb_pkg::NUM_W-1:0] num_reg;
    logic [ttb_pkg::NUM_W-1:0] rem_reg, quo_reg;
    logic [ttb_pkg::DET_W-1:0] dabs_reg;
    logic neg_reg;
    logic [ttb_pkg::QCNT_W-1:0] cnt_reg;
    logic [31:0] vec_reg [6];
    logic signed [ttb_pkg::EDGE_W-1:0] ea, eb;
    logic signed [ttb_pkg::DUV_W-1:0] da, db;
    logic signed [ttb_pkg::PROD_W-1:0] pr;
    logic signed [ttb_pkg::NUM_W-1:0] num_full;
    logic [ttb_pkg::NUM_W-1:0] num_abs;
    logic [ttb_pkg::NUM_W:0] trial;
    logic [ttb_pkg::NUM_W-1:0] rem_sh;
    logic [31:0] qsat;

    always_ff @(posedge clk)
    begin
        if (corner_we)
        begin
            if (!corner_sel)
            begin
                pa_reg[0] <= pos_x; pa_reg[1] <= pos_y; pa_reg[2] <= pos_z;
                ua_reg <= tex_u; va_reg <= tex_v; ia_reg <= vertex_index;
            end
            else
            begin
                pb_reg[0] <= pos_x; pb_reg[1] <= pos_y; pb_reg[2] <= pos_z;
                ub_reg <= tex_u; vb_reg <= tex_v; ib_reg <= vertex_index;
            end
        end
        if (tri_load)
        begin
            e1_reg[0] <= EDGE_W'(pb_reg[0]) - EDGE_W'(pa_reg[0]);
            e1_reg[1] <= EDGE_W'(pb_reg[1]) - EDGE_W'(pa_reg[1]);
            e1_reg[2] <= EDGE_W'(pb_reg[2]) - EDGE_W'(pa_reg[2]);
            e2_reg[0] <= EDGE_W'(pos_x) - EDGE_W'(pa_reg[0]);
            e2_reg[1] <= EDGE_W'(pos_y) - EDGE_W'(pa_reg[1]);
            e2_reg[2] <= EDGE_W'(pos_z) - EDGE_W'(pa_reg[2]);
            d1u_reg <= DUV_W'(ub_reg) - DUV_W'(ua_reg);
            d1v_reg <= DUV_W'(vb_reg) - DUV_W'(va_reg);
            d2u_reg <= DUV_W'(tex_u) - DUV_W'(ua_reg);
            d2v_reg <= DUV_W'(tex_v) - DUV_W'(va_reg);
            ic_reg <= vertex_index;
        end
    end

    // operand select: sel_bit picks first or second product of the term
    always_comb
    begin
        unique case (cmd.sel)
            3'd0, 3'd1, 3'd2:
            begin
                ea = cmd.sel_bit ? e2_reg[cmd.sel[1:0]] : e1_reg[cmd.sel[1:0]];
                da = cmd.sel_bit ? d1v_reg : d2v_reg;
            end
            3'd3, 3'd4, 3'd5:
            begin
                ea = cmd.sel_bit ? e1_reg[cmd.sel[1:0] - 2'd3 + 2'd0]
                                 : e2_reg[cmd.sel[1:0] - 2'd3 + 2'd0];
                da = cmd.sel_bit ? d2u_reg : d1u_reg;
            end
            default:
            begin
                // determinant terms
                ea = cmd.sel_bit ? EDGE_W'(d1v_reg) : EDGE_W'(d1u_reg);
                da = cmd.sel_bit ? d2u_reg : d2v_reg;
            end
        endcase
        eb = ea;
        db = da;
    end

    assign pr = ttb_pkg::PROD_W'(eb) * ttb_pkg::PROD_W'(db);
    assign num_full = (ttb_pkg::NUM_W'(p1_reg) - ttb_pkg::NUM_W'(p2_reg)) <<< 12;
    assign num_abs = num_reg[ttb_pkg::NUM_W-1] ? ttb_pkg::NUM_W'(-num_reg)
                                                : ttb_pkg::NUM_W'(num_reg);
    assign rem_sh = {rem_reg[ttb_pkg::NUM_W-2:0], quo_reg[ttb_pkg::NUM_W-1]};
    assign trial = {1'b0, rem_sh} - {{(ttb_pkg::NUM_W-ttb_pkg::DET_W+1){1'b0}}, dabs_reg};

    always_comb
    begin
        if (quo_reg[ttb_pkg::NUM_W-1:31] != '0)
            qsat = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (neg_reg)
            qsat = 32'(-$signed({1'b0, quo_reg[30:0]}));
        else
            qsat = {1'b0, quo_reg[30:0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            if (cmd.sel_bit) p2_reg <= pr;
            else             p1_reg <= pr;
        end
        if (cmd.load_det)
            det_reg <= ttb_pkg::DET_W'(p1_reg) - ttb_pkg::DET_W'(p2_reg);
        if (cmd.div_start)
        begin
            num_reg  <= num_full;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            if (cnt_reg == '0)
            begin
                // first step sets up magnitudes
                quo_reg  <= num_abs;
                rem_reg  <= '0;
                dabs_reg <= det_reg[ttb_pkg::DET_W-1] ? ttb_pkg::DET_W'(-det_reg)
                                                      : ttb_pkg::DET_W'(det_reg);
                neg_reg  <= num_reg[ttb_pkg::NUM_W-1] ^ det_reg[ttb_pkg::DET_W-1];
            end
            else if (!trial[ttb_pkg::NUM_W])
            begin
                rem_reg <= trial[ttb_pkg::NUM_W-1:0];
                quo_reg <= {quo_reg[ttb_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[ttb_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.store_q)
            vec_reg[cmd.sel] <= (det_reg == '0) ? 32'd0 : qsat;
    end

    assign stat.div_done = (cnt_reg == ttb_pkg::QCNT_W'(ttb_pkg::NUM_W));
    assign stat.det_zero = (det_reg == '0);
    assign index_a = ia_reg;
    assign index_b = ib_reg;
    assign index_c = ic_reg;
    assign vec = {vec_reg[5], vec_reg[4], vec_reg[3], vec_reg[2], vec_reg[1], vec_reg[0]};
endmodule

### sv/ttb_ctrl.sv
// controller: corner count, term sequencing and output handshake
module ttb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            in_last,
    input  logic            out_ready,
    input  ttb_pkg::stat_t  stat,
    output logic            s_ready,
    output logic            out_valid,
    output logic            corner_we,
    output logic            corner_sel,
    output logic            tri_load,
    output logic            done_flag,
    output ttb_pkg::cmd_t   cmd
);
    ttb_pkg::state_t state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic [2:0] sel_reg, sel_next;
    logic       ph_reg, ph_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::ST_IDLE;
            count_reg <= 2'd0;
            sel_reg   <= 3'd0;
            ph_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sel_reg   <= sel_next;
            ph_reg    <= ph_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sel_next   = sel_reg;
        ph_next    = ph_reg;
        done_next  = done_reg;
        unique case (state_reg)
            ttb_pkg::ST_IDLE:
                if (in_fire)
                begin
                    if (count_reg == 2'd2)
                    begin
                        count_next = 2'd0;
                        done_next  = in_last;
                        state_next = ttb_pkg::ST_DET;
                        sel_next   = 3'd6;
                        ph_next    = 1'b0;
                    end
                    else
                        count_next = in_last ? 2'd0 : count_reg + 2'd1;
                end
            ttb_pkg::ST_DET:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                begin
                    state_next = ttb_pkg::ST_NUM;
                    sel_next   = 3'd0;
                end
            end
            ttb_pkg::ST_NUM:
            begin
                ph_next = ~ph_reg;
                if (ph_reg)
                    state_next = ttb_pkg::ST_DIV_START;
            end
            ttb_pkg::ST_DIV_START:
                state_next = stat.det_zero ? ttb_pkg::ST_OUT : ttb_pkg::ST_DIV_RUN;
            ttb_pkg::ST_DIV_RUN:
                if (stat.div_done)
                    state_next = ttb_pkg::ST_OUT;
            ttb_pkg::ST_OUT:
                if (sel_reg != 3'd5 && sel_reg != 3'd6)
                begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = ttb_pkg::ST_NUM;
                end
                else if (sel_reg == 3'd5)
                    sel_next = 3'd6;
                else if (out_ready)
                    state_next = ttb_pkg::ST_IDLE;
            default:
                state_next = ttb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_ready    = (state_reg == ttb_pkg::ST_IDLE);
        out_valid  = (state_reg == ttb_pkg::ST_OUT) && (sel_reg == 3'd6);
        corner_we  = in_fire && (count_reg != 2'd2);
        corner_sel = count_reg[0];
        tri_load   = in_fire && (count_reg == 2'd2);
        done_flag  = done_reg;
        cmd.sel       = sel_reg;
        cmd.sel_bit   = ph_reg;
        cmd.mul_step  = (state_reg == ttb_pkg::ST_DET) || (state_reg == ttb_pkg::ST_NUM);
        cmd.load_det  = (state_reg == ttb_pkg::ST_NUM) && (sel_reg == 3'd0) && !ph_reg;
        cmd.div_start = (state_reg == ttb_pkg::ST_DIV_START);
        cmd.div_step  = (state_reg == ttb_pkg::ST_DIV_RUN);
        cmd.store_q   = (state_reg == ttb_pkg::ST_OUT) && (sel_reg != 3'd6);
    end
endmodule
